>>> src/png_filter_block_cost_assert.svh
// ----------------------------------------------------------------------------
// png_filter_block_cost assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PNG_FILTER_BLOCK_COST_ASSERT_SVH
`define PNG_FILTER_BLOCK_COST_ASSERT_SVH

// property must hold at every edge out of reset
`define PFBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define PFBC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/pfbc_pkg.sv
// ----------------------------------------------------------------------------
// pfbc_pkg
// shared types, constants and arithmetic helpers of the block cost estimator
// ----------------------------------------------------------------------------
package pfbc_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 12;
  localparam int NFILT      = 5;
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int TOTAL_W    = 32;
  localparam int FILT_W     = 3;
  localparam int HEIGHT_CAP = 4096;
  localparam int CFG_RST    = 64;

  localparam logic [SUM_W-1:0] SUM_MAX = 12'd4095;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 4'd1;

  localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
  localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
  localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
  localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
  localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic col_first;
    logic row_first;
    logic bcol_first;
    logic bcol_last;
    logic brow_first;
    logic brow_last;
    logic img_last;
  } pos_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] upleft;
    pos_flags_t       flags;
  } fe_item_t;

  typedef logic [NFILT-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic [SUM_W-1:0]   cost;
    logic [FILT_W-1:0]  filt;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } result_t;

  function automatic logic [PIX_W-1:0] absdiff8(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // |left + up - 2*upleft|
  function automatic logic [PIX_W:0] paeth_pc(input logic [PIX_W-1:0] l,
                                              input logic [PIX_W-1:0] u,
                                              input logic [PIX_W-1:0] ul);
    logic [PIX_W+1:0] s;
    logic [PIX_W+1:0] t;
    logic [PIX_W+1:0] d;
    s = (PIX_W+2)'(l) + (PIX_W+2)'(u);
    t = {1'b0, ul, 1'b0};
    d = (s >= t) ? (s - t) : (t - s);
    return d[PIX_W:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

>>> src/png_filter_block_cost.sv
// ----------------------------------------------------------------------------
// png_filter_block_cost
// per-block cost of the five png filters over a raster grayscale image
// usage:
//   pixels enter in raster order on push/full, one beat per pixel; a pixel is
//   taken at an edge with push high and full low
//   one result beat leaves per BLOCK_W x BLOCK_H block, on its last pixel, on
//   empty/pop: smallest filter sum, winning filter, running image total and
//   the last-block flag; the total clears after the last block of an image
//   image width and height are written on the cfg channel (valid/ready, ready
//   always high) only while idle, user-enforced; a write restarts the image
// timing:
//   one pixel per cycle sustained while full is low; a block's last pixel
//   then runs through front stage, queue, five back stages, results
//   the row-above memory and the block-sum memory each take one read and one
//   write per cycle, which sets the rate
// reset and stall:
//   reset empties all stages and queues and restores 64 x 64; when the
//   receiver stops popping, the back stalls, the queue fills and full rises
// ----------------------------------------------------------------------------
module png_filter_block_cost import pfbc_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int BLOCK_W   = 4,
  parameter int BLOCK_H   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 empty,
  input  logic                 pop,
  output logic [SUM_W-1:0]     out_block_cost,
  output logic [FILT_W-1:0]    out_best_filter,
  output logic [TOTAL_W-1:0]   out_running_total,
  output logic                 out_image_done,
  input  logic                 valid,
  output logic                 ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int NBLK = (MAX_WIDTH + BLOCK_W - 1) / BLOCK_W;
  localparam int BKW  = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int W_RST_CL = (CFG_RST < BLOCK_W) ? BLOCK_W :
                            ((CFG_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_RST);
  localparam int H_RST_CL = (CFG_RST < BLOCK_H) ? BLOCK_H :
                            ((CFG_RST > HEIGHT_CAP) ? HEIGHT_CAP : CFG_RST);

  logic [CW-1:0]    w_thr_r, w_thr_nxt;
  logic [ROW_W-1:0] h_thr_r, h_thr_nxt;
  logic [31:0]      cfg_val;
  logic [31:0]      w_cl;
  logic [31:0]      h_cl;
  logic             cfg_wr;
  logic             restart;

  logic           q_push;
  fe_item_t       q_wr_item;
  logic [BKW-1:0] q_wr_blk;
  logic           q_full;
  logic           q_pop;
  fe_item_t       q_rd_item;
  logic [BKW-1:0] q_rd_blk;
  logic           q_empty;
  result_t        head;

  assign ready   = 1'b1;
  assign cfg_wr  = valid & ready;
  assign restart = cfg_wr && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT);

  // row ends on the last block that still fits inside the clamped size
  always_comb begin
    cfg_val = 32'(cfg_data);
    w_cl = (cfg_val < 32'(BLOCK_W)) ? 32'(BLOCK_W) :
           ((cfg_val > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_val);
    h_cl = (cfg_val < 32'(BLOCK_H)) ? 32'(BLOCK_H) :
           ((cfg_val > 32'(HEIGHT_CAP)) ? 32'(HEIGHT_CAP) : cfg_val);
    w_thr_nxt = CW'(w_cl - 32'(BLOCK_W));
    h_thr_nxt = ROW_W'(h_cl - 32'(BLOCK_H));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_thr_r <= CW'(W_RST_CL - BLOCK_W);
      h_thr_r <= ROW_W'(H_RST_CL - BLOCK_H);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  w_thr_r <= w_thr_nxt;
        CFG_IDX_HEIGHT: h_thr_r <= h_thr_nxt;
        default:        w_thr_r <= w_thr_r;
      endcase
    end
  end

  pfbc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .BLOCK_W   (BLOCK_W),
    .BLOCK_H   (BLOCK_H)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .w_thr   (w_thr_r),
    .h_thr   (h_thr_r),
    .push    (push),
    .pixel   (in_pixel),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item),
    .q_blk   (q_wr_blk)
  );

  pfbc_queue #(
    .BKW (BKW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .wr_blk  (q_wr_blk),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .rd_blk  (q_rd_blk),
    .q_empty (q_empty)
  );

  pfbc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .BLOCK_W   (BLOCK_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_rd_item),
    .q_blk     (q_rd_blk),
    .out_pop   (pop),
    .out_empty (empty),
    .out_head  (head)
  );

  assign out_block_cost    = head.cost;
  assign out_best_filter   = head.filt;
  assign out_running_total = head.total;
  assign out_image_done    = head.last;

endmodule

>>> src/pfbc_front.sv
// ----------------------------------------------------------------------------
// pfbc_front
// accepts pixels, tracks raster position, keeps the row above, forms neighbors
// ----------------------------------------------------------------------------
module pfbc_front import pfbc_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int BLOCK_W   = 4,
  parameter int BLOCK_H   = 4,
  localparam int CW   = $clog2(MAX_WIDTH),
  localparam int NBLK = (MAX_WIDTH + BLOCK_W - 1) / BLOCK_W,
  localparam int BKW  = (NBLK > 1) ? $clog2(NBLK) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [CW-1:0]    w_thr,
  input  logic [ROW_W-1:0] h_thr,
  input  logic             push,
  input  logic [PIX_W-1:0] pixel,
  output logic             full,
  input  logic             q_full,
  output logic             q_push,
  output fe_item_t         q_item,
  output logic [BKW-1:0]   q_blk
);

  localparam int SCW = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
  localparam int SRW = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;

  logic [CW-1:0]    col_r, col_nxt;
  logic [SCW-1:0]   sub_col_r, sub_col_nxt;
  logic [BKW-1:0]   blk_r, blk_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SRW-1:0]   sub_row_r, sub_row_nxt;

  logic             f1_v_r;
  logic [PIX_W-1:0] f1_pix_r;
  logic [BKW-1:0]   f1_blk_r;
  pos_flags_t       f1_flags_r;
  logic [PIX_W-1:0] up_rd_r;
  logic [PIX_W-1:0] last_pix_r;
  logic [PIX_W-1:0] last_up_r;

  logic [PIX_W-1:0] row_mem [MAX_WIDTH];

  logic       accept;
  logic       drain;
  logic       last_sub_col;
  logic       last_sub_row;
  logic       row_end;
  logic       img_end;
  pos_flags_t cur_flags;
  logic [PIX_W-1:0] up_val;

  assign full   = f1_v_r & q_full;
  assign accept = push & ~full;
  assign drain  = f1_v_r & ~q_full;

  always_comb begin
    last_sub_col = (sub_col_r == SCW'(BLOCK_W - 1));
    last_sub_row = (sub_row_r == SRW'(BLOCK_H - 1));
    row_end      = last_sub_col && (col_r >= w_thr);
    img_end      = row_end && last_sub_row && (row_r >= h_thr);

    cur_flags.col_first  = (col_r == '0);
    cur_flags.row_first  = (row_r == '0);
    cur_flags.bcol_first = (sub_col_r == '0);
    cur_flags.bcol_last  = last_sub_col;
    cur_flags.brow_first = (sub_row_r == '0);
    cur_flags.brow_last  = last_sub_row;
    cur_flags.img_last   = img_end;

    col_nxt     = col_r + 1'b1;
    sub_col_nxt = last_sub_col ? '0 : sub_col_r + 1'b1;
    blk_nxt     = last_sub_col ? blk_r + 1'b1 : blk_r;
    row_nxt     = row_r;
    sub_row_nxt = sub_row_r;
    if (row_end) begin
      col_nxt     = '0;
      sub_col_nxt = '0;
      blk_nxt     = '0;
      if (img_end) begin
        row_nxt     = '0;
        sub_row_nxt = '0;
      end else begin
        row_nxt     = row_r + 1'b1;
        sub_row_nxt = last_sub_row ? '0 : sub_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r     <= '0;
      sub_col_r <= '0;
      blk_r     <= '0;
      row_r     <= '0;
      sub_row_r <= '0;
    end else if (accept) begin
      col_r     <= col_nxt;
      sub_col_r <= sub_col_nxt;
      blk_r     <= blk_nxt;
      row_r     <= row_nxt;
      sub_row_r <= sub_row_nxt;
    end
  end

  // row above: read old value and overwrite at the same address
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r        <= row_mem[col_r];
      row_mem[col_r] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (accept) begin
      f1_v_r <= 1'b1;
    end else if (drain) begin
      f1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix_r   <= pixel;
      f1_blk_r   <= blk_r;
      f1_flags_r <= cur_flags;
    end
  end

  assign up_val = f1_flags_r.row_first ? '0 : up_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      last_pix_r <= '0;
      last_up_r  <= '0;
    end else if (drain) begin
      last_pix_r <= f1_pix_r;
      last_up_r  <= up_val;
    end
  end

  always_comb begin
    q_push        = drain;
    q_blk         = f1_blk_r;
    q_item.pix    = f1_pix_r;
    q_item.left   = f1_flags_r.col_first ? '0 : last_pix_r;
    q_item.up     = up_val;
    q_item.upleft = (f1_flags_r.col_first || f1_flags_r.row_first) ? '0 : last_up_r;
    q_item.flags  = f1_flags_r;
  end

endmodule

>>> src/pfbc_queue.sv
// ----------------------------------------------------------------------------
// pfbc_queue
// short queue of classified pixels between the front and the back
// ----------------------------------------------------------------------------
module pfbc_queue import pfbc_pkg::*; #(
  parameter int BKW = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  fe_item_t       wr_item,
  input  logic [BKW-1:0] wr_blk,
  output logic           q_full,
  input  logic           rd_en,
  output fe_item_t       rd_item,
  output logic [BKW-1:0] rd_blk,
  output logic           q_empty
);

  fe_item_t       item_mem [QUEUE_DEPTH];
  logic [BKW-1:0] blk_mem  [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic do_wr;
  logic do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_item = item_mem[rd_ptr_r];
  assign rd_blk  = blk_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      item_mem[wr_ptr_r] <= wr_item;
      blk_mem[wr_ptr_r]  <= wr_blk;
    end
  end

endmodule

>>> src/pfbc_back.sv
// ----------------------------------------------------------------------------
// pfbc_back
// residuals, per-block filter sums, winner selection, running total, results
// ----------------------------------------------------------------------------
`include "png_filter_block_cost_assert.svh"

module pfbc_back import pfbc_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int BLOCK_W   = 4,
  localparam int NBLK = (MAX_WIDTH + BLOCK_W - 1) / BLOCK_W,
  localparam int BKW  = (NBLK > 1) ? $clog2(NBLK) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           restart,
  input  logic           q_empty,
  output logic           q_pop,
  input  fe_item_t       q_item,
  input  logic [BKW-1:0] q_blk,
  input  logic           out_pop,
  output logic           out_empty,
  output result_t        out_head
);

  logic adv;

  // stage 1: simple residuals and paeth distances
  logic             b1_v_r;
  fe_item_t         b1_it_r;
  logic [BKW-1:0]   b1_blk_r;
  logic [3:0][PIX_W-1:0] b1_res_r;
  logic [PIX_W-1:0] b1_pa_r;
  logic [PIX_W-1:0] b1_pb_r;
  logic [PIX_W:0]   b1_pc_r;
  logic [3:0][PIX_W-1:0] res_c;
  logic [PIX_W:0]   avg_sum;

  // stage 2: row partial sums of the current block
  logic             b2_v_r;
  pos_flags_t       b2_flags_r;
  logic [BKW-1:0]   b2_blk_r;
  sums_t            part_r;
  sums_t            part_nxt;
  logic [PIX_W-1:0] pred;
  logic [NFILT-1:0][PIX_W-1:0] res_all;

  // stage 3: block sum read-modify-write
  logic             b3_v_r;
  pos_flags_t       b3_flags_r;
  logic [BKW-1:0]   b3_blk_r;
  sums_t            b3_part_r;
  sums_t            bs_mem [NBLK];
  sums_t            bs_rd_r;
  sums_t            fwd_data_r;
  logic             fwd_r;
  sums_t            prev_sums;
  sums_t            sum3;
  logic             bs_we;

  // stage 4: complete block sums
  logic             b4_v_r;
  sums_t            b4_sums_r;
  logic             b4_last_r;
  logic [SUM_W-1:0] best_c;
  logic [FILT_W-1:0] which_c;

  // stage 5: winner
  logic              b5_v_r;
  logic [SUM_W-1:0]  b5_cost_r;
  logic [FILT_W-1:0] b5_filt_r;
  logic              b5_last_r;

  // result queue
  result_t            of_mem [OUT_DEPTH];
  logic [OPTR_W-1:0]  of_wr_r;
  logic [OPTR_W-1:0]  of_rd_r;
  logic [OCNT_W-1:0]  of_cnt_r;
  logic               of_full;
  logic               of_push;
  logic               of_pop;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_sum;
  result_t            of_entry;

  assign of_full   = (of_cnt_r == OCNT_W'(OUT_DEPTH));
  assign out_empty = (of_cnt_r == '0);
  assign adv       = ~(b5_v_r & of_full);
  assign q_pop     = adv & ~q_empty;
  assign of_push   = b5_v_r & ~of_full;
  assign of_pop    = out_pop & ~out_empty;
  assign out_head  = of_mem[of_rd_r];

  always_comb begin
    avg_sum  = (PIX_W+1)'(q_item.left) + (PIX_W+1)'(q_item.up);
    res_c[0] = q_item.pix;
    res_c[1] = absdiff8(q_item.pix, q_item.left);
    res_c[2] = absdiff8(q_item.pix, q_item.up);
    res_c[3] = absdiff8(q_item.pix, avg_sum[PIX_W:1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_it_r  <= q_item;
      b1_blk_r <= q_blk;
      b1_res_r <= res_c;
      b1_pa_r  <= absdiff8(q_item.up, q_item.upleft);
      b1_pb_r  <= absdiff8(q_item.left, q_item.upleft);
      b1_pc_r  <= paeth_pc(q_item.left, q_item.up, q_item.upleft);
    end
  end

  always_comb begin
    if ((PIX_W+1)'(b1_pa_r) <= b1_pc_r && b1_pa_r <= b1_pb_r) begin
      pred = b1_it_r.left;
    end else if ((PIX_W+1)'(b1_pb_r) <= b1_pc_r) begin
      pred = b1_it_r.up;
    end else begin
      pred = b1_it_r.upleft;
    end
    res_all[0] = b1_res_r[0];
    res_all[1] = b1_res_r[1];
    res_all[2] = b1_res_r[2];
    res_all[3] = b1_res_r[3];
    res_all[4] = absdiff8(b1_it_r.pix, pred);
    for (int k = 0; k < NFILT; k++) begin
      part_nxt[k] = sat_add(b1_it_r.flags.bcol_first ? '0 : part_r[k],
                            SUM_W'(res_all[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_flags_r <= b1_it_r.flags;
      b2_blk_r   <= b1_blk_r;
      if (b1_v_r) begin
        part_r <= part_nxt;
      end
    end
  end

  always_comb begin
    prev_sums = fwd_r ? fwd_data_r : bs_rd_r;
    for (int k = 0; k < NFILT; k++) begin
      sum3[k] = b3_flags_r.brow_first ? b3_part_r[k] : sat_add(prev_sums[k], b3_part_r[k]);
    end
  end

  assign bs_we = adv & b3_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      bs_rd_r <= bs_mem[b2_blk_r];
    end
    if (bs_we) begin
      bs_mem[b3_blk_r] <= sum3;
    end
  end

  // write and read of the same block column on one edge
  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_r      <= bs_we && (b3_blk_r == b2_blk_r);
      fwd_data_r <= sum3;
      b3_flags_r <= b2_flags_r;
      b3_blk_r   <= b2_blk_r;
      b3_part_r  <= part_r;
      b4_sums_r  <= sum3;
      b4_last_r  <= b3_flags_r.img_last;
    end
  end

  always_comb begin
    best_c  = b4_sums_r[0];
    which_c = FILT_NONE;
    for (int k = 1; k < NFILT; k++) begin
      if (b4_sums_r[k] < best_c) begin
        best_c  = b4_sums_r[k];
        which_c = FILT_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_cost_r <= best_c;
      b5_filt_r <= which_c;
      b5_last_r <= b4_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r <= ~q_empty;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r & b2_flags_r.bcol_last;
      b4_v_r <= b3_v_r & b3_flags_r.brow_last;
      b5_v_r <= b4_v_r;
    end
  end

  always_comb begin
    total_sum      = total_r + TOTAL_W'(b5_cost_r);
    of_entry.cost  = b5_cost_r;
    of_entry.filt  = b5_filt_r;
    of_entry.total = total_sum;
    of_entry.last  = b5_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      total_r <= '0;
    end else if (of_push) begin
      total_r <= b5_last_r ? '0 : total_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= '0;
      of_rd_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      if (of_push) begin
        of_wr_r <= of_wr_r + 1'b1;
      end
      if (of_pop) begin
        of_rd_r <= of_rd_r + 1'b1;
      end
      case ({of_push, of_pop})
        2'b10:   of_cnt_r <= of_cnt_r + 1'b1;
        2'b01:   of_cnt_r <= of_cnt_r - 1'b1;
        default: of_cnt_r <= of_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (of_push) begin
      of_mem[of_wr_r] <= of_entry;
    end
  end

  `PFBC_ASSERT_NEVER(a_of_cnt_range, of_cnt_r > OCNT_W'(OUT_DEPTH), "result queue overflow")
  `PFBC_ASSERT(a_total_clear, (of_push && b5_last_r) |=> (total_r == '0), "total not cleared")
  `PFBC_ASSERT(a_stall_hold, (b5_v_r && !adv) |=> (b5_v_r && $stable(b5_cost_r)), "winner lost")

endmodule
